@@ design/bvw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bvw_pkg;

  // Command codes carried in the op field.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_VARINT = 2'd2
  } op_e;

  // Largest bit count an append honors; larger counts saturate here.
  localparam logic [5:0] MAX_BITS = 6'd32;

  // Most bytes one command can produce.
  localparam int unsigned MAX_BYTES = 5;

  // Prefixes of the prefix-length varint, one per encoded length of two to five bytes.
  localparam logic [7:0] PFX_LEN2 = 8'h80;
  localparam logic [7:0] PFX_LEN3 = 8'hC0;
  localparam logic [7:0] PFX_LEN4 = 8'hE0;
  localparam logic [7:0] PFX_LEN5 = 8'hF0;

  // One queued burst: up to five bytes, first byte at index zero.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Reverses a 32-bit word so that bit zero lands in bit 31.
  function automatic logic [31:0] bit_rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/bvw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Command channel.
interface bvw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] value;
  logic [5:0]  bit_count;

  modport source (output valid, output op, output value, output bit_count, input ready);
  modport sink   (input valid, input op, input value, input bit_count, output ready);
endinterface

// Output byte channel.
interface bvw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ design/bit_and_varint_stream_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                          Accept
// cmd_i     in   op[1:0] value[31:0] bit_count[5:0]   valid && ready
// byte_o    out  out_byte[7:0] last               valid && ready
//
// The front end decodes each command combinationally into a burst; the back end sends
// one word per cycle while byte_o.ready is high.
// A two-entry burst queue separates the two; cmd_i stalls only while it is full.
// Reset clears the pending bits, the queue and the output stage.
// With the queue empty and the output idle, the first byte of a command is written
// into the queue, then loaded into the burst register, and only then valid on byte_o.
module bit_and_varint_stream_writer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bvw_cmd_if.sink    cmd_i,
  bvw_byte_if.source byte_o
);
  import bvw_pkg::*;

  entry_t  ent;
  entry_t  head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  bvw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ent_o  (ent),
    .push_o (push)
  );

  bvw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (ent),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  bvw_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .byte_o (byte_o)
  );

  // A queued burst always carries one to five bytes.
  a_push_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (ent.len != 3'd0 && ent.len <= 3'd5))
    else $error("queued burst with bad length");

  // The queue never overflows.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> !stat.full)
    else $error("push into full queue");

  // The queue is never popped empty.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // A new burst loads only when the output stage is free or finishing.
  a_load_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!byte_o.valid || (byte_o.ready && byte_o.last)))
    else $error("burst loaded over a busy output");

endmodule

`default_nettype wire

@@ design/bvw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bvw_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  bvw_cmd_if.sink               cmd_i,
  input  wire bvw_pkg::q_stat_t stat_i,
  output bvw_pkg::entry_t       ent_o,
  output logic                  push_o
);
  import bvw_pkg::*;

  logic [7:0]  pb_q, pb_d;
  logic [2:0]  pc_q, pc_d;

  logic        fire;
  logic [5:0]  nbits;
  logic [32:0] mask;
  logic [31:0] rev;
  logic [39:0] hi, lo, w;
  logic [5:0]  total;
  logic [2:0]  nb;
  logic [2:0]  rem;
  logic [4:0][7:0] win;
  logic [7:0]  tail;
  logic [31:0] v;

  assign cmd_i.ready = !stat_i.full;
  assign fire        = cmd_i.valid && cmd_i.ready;
  assign v           = cmd_i.value;

  // Append datapath: pending bits on top, new bits reversed right behind them.
  always_comb begin
    nbits = (cmd_i.bit_count > MAX_BITS) ? MAX_BITS : cmd_i.bit_count;
    mask  = (33'd1 << nbits) - 33'd1;
    rev   = bit_rev32(v & mask[31:0]);
    hi    = {pb_q, 32'd0} << (4'd8 - {1'b0, pc_q});
    lo    = {rev, 8'd0} >> pc_q;
    w     = hi | lo;
    total = {3'd0, pc_q} + nbits;
    nb    = total[5:3];
    rem   = total[2:0];
    for (int k = 0; k < MAX_BYTES; k++) begin
      win[k] = w[39-8*k -: 8];
    end
    // The byte holding the leftover bits, right-aligned as the new pending byte.
    tail = win[nb] >> (4'd8 - {1'b0, rem});
  end

  // Command decode: the burst to queue and the next pending state.
  always_comb begin
    pb_d      = pb_q;
    pc_d      = pc_q;
    ent_o     = '0;
    case (cmd_i.op)
      OP_APPEND: begin
        ent_o.bytes = win;
        ent_o.len   = nb;
        pb_d        = tail;
        pc_d        = rem;
      end
      OP_FLUSH: begin
        ent_o.bytes[0] = pb_q;
        ent_o.len      = (pc_q != 3'd0) ? 3'd1 : 3'd0;
        pb_d           = '0;
        pc_d           = '0;
      end
      OP_VARINT: begin
        if (v[31:7] == '0) begin
          ent_o.bytes[0] = v[7:0];
          ent_o.len      = 3'd1;
        end else if (v[31:14] == '0) begin
          ent_o.bytes[0] = PFX_LEN2 | v[15:8];
          ent_o.bytes[1] = v[7:0];
          ent_o.len      = 3'd2;
        end else if (v[31:21] == '0) begin
          ent_o.bytes[0] = PFX_LEN3 | v[23:16];
          ent_o.bytes[1] = v[15:8];
          ent_o.bytes[2] = v[7:0];
          ent_o.len      = 3'd3;
        end else if (v[31:28] == '0) begin
          ent_o.bytes[0] = PFX_LEN4 | v[31:24];
          ent_o.bytes[1] = v[23:16];
          ent_o.bytes[2] = v[15:8];
          ent_o.bytes[3] = v[7:0];
          ent_o.len      = 3'd4;
        end else begin
          ent_o.bytes[0] = PFX_LEN5;
          ent_o.bytes[1] = v[31:24];
          ent_o.bytes[2] = v[23:16];
          ent_o.bytes[3] = v[15:8];
          ent_o.bytes[4] = v[7:0];
          ent_o.len      = 3'd5;
        end
      end
      default: begin
        ent_o.len = 3'd0;
      end
    endcase
  end

  // Only commands that produce bytes enter the queue.
  assign push_o = fire && (ent_o.len != 3'd0);

  // Pending byte state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q <= '0;
      pc_q <= '0;
    end else if (fire) begin
      pb_q <= pb_d;
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bvw_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bvw_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bvw_pkg::entry_t  ent_i,
  input  wire logic             pop_i,
  output bvw_pkg::entry_t       head_o,
  output bvw_pkg::q_stat_t      stat_o
);
  import bvw_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rp_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= ent_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bvw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bvw_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bvw_pkg::entry_t  head_i,
  input  wire bvw_pkg::q_stat_t stat_i,
  output logic                  pop_o,
  bvw_byte_if.source            byte_o
);
  import bvw_pkg::*;

  entry_t     cur_q;
  logic [2:0] idx_q;
  logic       busy_q;
  logic       fire;
  logic       is_last;

  assign is_last       = (idx_q == cur_q.len - 3'd1);
  assign byte_o.valid    = busy_q;
  assign byte_o.out_byte = cur_q.bytes[idx_q];
  assign byte_o.last     = is_last;
  assign fire            = busy_q && byte_o.ready;

  // Take the next burst when idle or when the current one hands over its last word.
  assign pop_o = !stat_i.empty && (!busy_q || (fire && is_last));

  // Burst register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // Byte index and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      busy_q <= !is_last;
      idx_q  <= idx_q + 3'd1;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_bit_and_varint_stream_writer.sv @@
`timescale 1ns / 1ps

module tb_bit_and_varint_stream_writer;
  import bvw_pkg::*;

  // The op field also carries a code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_PER_PHASE = 65;

  logic clk;
  logic rst_n;

  bvw_cmd_if  cmd_if ();
  bvw_byte_if byte_if ();

  bit_and_varint_stream_writer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .byte_o (byte_if)
  );

  // Expected output stream, one entry per word on the byte channel.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t exp_stream[$];

  // Shadow of the bit packer state.
  logic [7:0] shadow_bits;
  logic [2:0] shadow_count;

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Work out the bytes one command produces and update the shadow state.
  function automatic void predict_command(input logic [1:0] op, input logic [31:0] value,
                                          input logic [5:0] bit_count);
    logic [7:0] burst[$];
    logic [5:0] n;
    stream_byte_t e;
    case (op)
      OP_APPEND: begin
        n = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
        for (int i = 0; i < n; i++) begin
          shadow_bits = {shadow_bits[6:0], value[i]};
          if (shadow_count == 3'd7) begin
            burst.push_back(shadow_bits);
            shadow_bits  = '0;
            shadow_count = '0;
          end else begin
            shadow_count++;
          end
        end
      end
      OP_FLUSH: begin
        if (shadow_count != 3'd0) begin
          burst.push_back(shadow_bits);
        end
        shadow_bits  = '0;
        shadow_count = '0;
      end
      OP_VARINT: begin
        if (value < 32'h0000_0080) begin
          burst.push_back(value[7:0]);
        end else if (value < 32'h0000_4000) begin
          burst.push_back(PFX_LEN2 | value[15:8]);
          burst.push_back(value[7:0]);
        end else if (value < 32'h0020_0000) begin
          burst.push_back(PFX_LEN3 | value[23:16]);
          burst.push_back(value[15:8]);
          burst.push_back(value[7:0]);
        end else if (value < 32'h1000_0000) begin
          burst.push_back(PFX_LEN4 | value[31:24]);
          burst.push_back(value[23:16]);
          burst.push_back(value[15:8]);
          burst.push_back(value[7:0]);
        end else begin
          burst.push_back(PFX_LEN5);
          burst.push_back(value[31:24]);
          burst.push_back(value[23:16]);
          burst.push_back(value[15:8]);
          burst.push_back(value[7:0]);
        end
      end
      default: begin
      end
    endcase
    foreach (burst[i]) begin
      e.data = burst[i];
      e.last = (i == burst.size() - 1);
      exp_stream.push_back(e);
    end
  endfunction

  // Present one command word, wait for its acceptance, then idle at random.
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] value,
                          input logic [5:0] bit_count);
    int unsigned gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.op        <= op;
    cmd_if.value     <= value;
    cmd_if.bit_count <= bit_count;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_command(op, value, bit_count);
    gap = 0;
    while (gap < 64 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the command channel idle until the whole expected stream has come out.
  task automatic wait_for_drain();
    cmd_if.valid <= 1'b0;
    while (exp_stream.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Compare each accepted byte with the oldest expected one; drive ready at random.
  always @(posedge clk) begin
    stream_byte_t e;
    if (rst_n && byte_if.valid && byte_if.ready) begin
      if (exp_stream.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  byte_if.out_byte, byte_if.last));
      end else begin
        e = exp_stream.pop_front();
        if (byte_if.out_byte !== e.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", byte_if.out_byte, e.data));
        end
        if (byte_if.last !== e.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                    byte_if.last, e.last, e.data));
        end
      end
    end
    byte_if.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Full and empty counts, saturation of the count, and byte completion.
  task automatic test_append_edges();
    send_cmd(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
    send_cmd(OP_APPEND, 32'h1234_5678, 6'd0);
    send_cmd(OP_APPEND, 32'h0000_0001, 6'd1);
    send_cmd(OP_APPEND, 32'h0000_0055, 6'd7);
    send_cmd(OP_APPEND, 32'hA5A5_A5A5, 6'd63);
    send_cmd(OP_APPEND, 32'h0000_0000, 6'd33);
    // Seven pending bits plus a full word gives the longest append burst.
    send_cmd(OP_APPEND, 32'h0000_007F, 6'd7);
    send_cmd(OP_APPEND, 32'hDEAD_BEEF, 6'd32);
    send_cmd(OP_FLUSH, 32'h0, 6'd0);
  endtask

  // Flush with nothing pending, flush of a partial byte, and a repeated flush.
  task automatic test_flush();
    send_cmd(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_cmd(OP_APPEND, 32'h0000_0005, 6'd3);
    send_cmd(OP_FLUSH, 32'h0, 6'd0);
    send_cmd(OP_FLUSH, 32'h0, 6'd0);
  endtask

  // Every length boundary of the varint, with pending bits that must survive.
  task automatic test_varint();
    send_cmd(OP_APPEND, 32'h0000_0013, 6'd5);
    send_cmd(OP_VARINT, 32'd0, 6'd0);
    send_cmd(OP_VARINT, 32'd127, 6'd0);
    send_cmd(OP_VARINT, 32'd128, 6'd0);
    send_cmd(OP_VARINT, 32'd16383, 6'd0);
    send_cmd(OP_VARINT, 32'd16384, 6'd0);
    send_cmd(OP_VARINT, 32'd2097151, 6'd0);
    send_cmd(OP_VARINT, 32'd2097152, 6'd0);
    send_cmd(OP_VARINT, 32'd268435455, 6'd0);
    send_cmd(OP_VARINT, 32'd268435456, 6'd0);
    send_cmd(OP_VARINT, 32'hFFFF_FFFF, 6'd63);
    send_cmd(OP_FLUSH, 32'h0, 6'd0);
  endtask

  // The unused op code must leave pending bits alone and produce nothing.
  task automatic test_unused_op();
    send_cmd(OP_APPEND, 32'h0000_0002, 6'd2);
    send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_cmd(OP_FLUSH, 32'h0, 6'd0);
  endtask

  // Random command mix, mostly appends and varints of every length.
  task automatic test_random(input int unsigned sender_pct, input int unsigned receiver_pct,
                             input int unsigned count);
    int unsigned sel;
    logic [1:0]  op;
    logic [31:0] value;
    logic [5:0]  bit_count;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (count) begin
      sel       = $urandom_range(99);
      value     = $urandom();
      bit_count = 6'($urandom_range(63));
      if (sel < 55) begin
        op = OP_APPEND;
        if ($urandom_range(9) != 0) bit_count = 6'($urandom_range(32));
      end else if (sel < 70) begin
        op = OP_FLUSH;
      end else if (sel < 95) begin
        op    = OP_VARINT;
        value = value >> $urandom_range(31);
      end else begin
        op = OP_UNUSED;
      end
      send_cmd(op, value, bit_count);
    end
    wait_for_drain();
  endtask

  // Reset, directed tests, then random phases under each idling pattern.
  initial begin
    rst_n              = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    shadow_bits        = '0;
    shadow_count       = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.op          = OP_APPEND;
    cmd_if.value       = '0;
    cmd_if.bit_count   = '0;
    byte_if.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_append_edges();
    test_flush();
    test_varint();
    test_unused_op();
    wait_for_drain();

    test_random(0, 0, RANDOM_PER_PHASE);
    test_random(84, 0, RANDOM_PER_PHASE);
    test_random(0, 84, RANDOM_PER_PHASE);
    test_random(16, 16, RANDOM_PER_PHASE);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
